// File: rtl/ile_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ile_pkg
// Shared widths, request and status codes, and controller/datapath types
// for the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int REQ_W     = 3;
	localparam int IDX_W     = 6;
	localparam int VAL_W     = 32;
	localparam int ST_W      = 2;
	localparam int LEN_W     = 7;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 48;

	localparam logic [REQ_W-1:0] REQ_ADD_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ADD_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_ADD_AT    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_REM_BACK  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_REM_AT    = 3'd5;
	localparam logic [REQ_W-1:0] REQ_READ      = 3'd6;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	localparam logic [VAL_W-1:0] ERR_VALUE = 32'hFFFF_FFFF;

	// controller to datapath
	typedef struct packed {
		logic load;    // latch request and decide it
		logic run;     // issue one store read of the walk
		logic commit;  // final write, count update, load output register
	} ile_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_done;  // no reads left to issue
		logic out_free;   // output register can take a result
	} ile_stat_t;

endpackage
`default_nettype wire

// File: rtl/ile_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ile_ctrl
// Request sequencer: accept, walk the store, commit the result.
// ----------------------------------------------------------------------------
module ile_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ile_pkg::ile_stat_t stat,
	output ile_pkg::ile_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_RUN    = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_RUN;
			end
			S_RUN: begin
				if (stat.walk_done) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.load   = (state_q == S_IDLE) && in_valid;
	assign cmd.run    = (state_q == S_RUN);
	assign cmd.commit = (state_q == S_FINISH) && stat.out_free;

endmodule
`default_nettype wire

// File: rtl/ile_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ile_dp
// Entry store, length counter, shift walk pipeline and output register.
// ----------------------------------------------------------------------------
module ile_dp #(
	parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ile_pkg::ile_cmd_t                cmd,
	output ile_pkg::ile_stat_t                    stat,
	input  wire logic [ile_pkg::REQ_W-1:0]        req_type,
	input  wire logic [ile_pkg::IDX_W-1:0]        item_index,
	input  wire logic signed [ile_pkg::VAL_W-1:0] item_value,
	output logic signed [ile_pkg::VAL_W-1:0]      result_value,
	output logic [ile_pkg::ST_W-1:0]              status,
	output logic [ile_pkg::LEN_W-1:0]             fill_level,
	output logic                                  out_valid,
	input  wire logic                             out_ready
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > ile_pkg::IDX_W) ? CW : ile_pkg::IDX_W;
	localparam int LW = (CW > ile_pkg::LEN_W) ? CW : ile_pkg::LEN_W;

	logic [ile_pkg::VAL_W-1:0] mem [CAPACITY];

	// control state
	logic [CW-1:0] count_q;
	logic [CW-1:0] left_q;
	logic [AW-1:0] rp_q;
	logic          first_q;
	logic          ins_q;
	logic          rem_q;
	logic          ok_q;
	logic          rv_s1;
	logic          out_valid_q;

	// payload
	logic [AW-1:0]             pos_q;
	logic [ile_pkg::VAL_W-1:0] val_q;
	logic [ile_pkg::VAL_W-1:0] res_q;
	logic [ile_pkg::ST_W-1:0]  st_q;
	logic [ile_pkg::VAL_W-1:0] rdata_s1;
	logic [AW-1:0]             wa_s1;
	logic                      first_s1;
	logic [ile_pkg::VAL_W-1:0] res_out_q;
	logic [ile_pkg::ST_W-1:0]  st_out_q;
	logic [ile_pkg::LEN_W-1:0] len_out_q;

	// request decision
	logic [XW-1:0]             cnt_x;
	logic [XW-1:0]             idx_x;
	logic [XW-1:0]             pos_x;
	logic [XW-1:0]             len_x;
	logic [XW-1:0]             rp_x;
	logic                      is_add;
	logic                      is_rem;
	logic                      dec_ok;
	logic [ile_pkg::ST_W-1:0]  dec_st;
	logic [ile_pkg::VAL_W-1:0] dec_res;

	always_comb begin
		cnt_x   = XW'(count_q);
		idx_x   = XW'(item_index);
		pos_x   = '0;
		is_add  = 1'b0;
		is_rem  = 1'b0;
		dec_ok  = 1'b0;
		dec_st  = ile_pkg::ST_OK;
		dec_res = '0;
		unique case (req_type)
			ile_pkg::REQ_ADD_FRONT, ile_pkg::REQ_ADD_BACK, ile_pkg::REQ_ADD_AT: begin
				is_add = 1'b1;
				if (req_type == ile_pkg::REQ_ADD_FRONT) pos_x = '0;
				else if (req_type == ile_pkg::REQ_ADD_BACK) pos_x = cnt_x;
				else pos_x = idx_x;
				if (count_q == CW'(CAPACITY)) dec_st = ile_pkg::ST_FULL;
				else if (pos_x > cnt_x) dec_st = ile_pkg::ST_RANGE;
				else dec_ok = 1'b1;
			end
			ile_pkg::REQ_REM_FRONT, ile_pkg::REQ_REM_BACK, ile_pkg::REQ_REM_AT: begin
				is_rem = 1'b1;
				if (req_type == ile_pkg::REQ_REM_FRONT) pos_x = '0;
				else if (req_type == ile_pkg::REQ_REM_BACK) pos_x = cnt_x - XW'(1);
				else pos_x = idx_x;
				if (count_q == '0 || pos_x >= cnt_x) begin
					dec_st  = ile_pkg::ST_RANGE;
					dec_res = ile_pkg::ERR_VALUE;
				end else begin
					dec_ok = 1'b1;
				end
			end
			ile_pkg::REQ_READ: begin
				pos_x = idx_x;
				if (idx_x >= cnt_x) begin
					dec_st  = ile_pkg::ST_RANGE;
					dec_res = ile_pkg::ERR_VALUE;
				end else begin
					dec_ok = 1'b1;
				end
			end
			default: dec_st = ile_pkg::ST_RANGE;
		endcase
		// reads of the walk: entries from pos to the end; a lookup reads one
		if (!dec_ok) len_x = '0;
		else if (is_add || is_rem) len_x = cnt_x - pos_x;
		else len_x = XW'(1);
		// insert walks down from the last entry, everything else walks up
		rp_x = is_add ? (cnt_x - XW'(1)) : pos_x;
	end

	// store write port
	logic                      we_c;
	logic [AW-1:0]             wa_c;
	logic [ile_pkg::VAL_W-1:0] wd_c;
	logic                      capture_c;

	assign capture_c = rv_s1 && first_s1 && !ins_q;

	always_comb begin
		we_c = 1'b0;
		wa_c = wa_s1;
		wd_c = rdata_s1;
		if (rv_s1 && !capture_c) begin
			we_c = 1'b1;
		end else if (cmd.commit && ins_q && ok_q) begin
			we_c = 1'b1;
			wa_c = pos_q;
			wd_c = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we_c) mem[wa_c] <= wd_c;
		rdata_s1 <= mem[rp_q];
	end

	logic issue_c;
	assign issue_c = cmd.run && (left_q != '0);

	// next length and its low bits for the result
	logic [CW-1:0] count_d;
	logic [LW-1:0] count_w;

	always_comb begin
		count_d = count_q;
		if (ok_q && ins_q) count_d = count_q + CW'(1);
		else if (ok_q && rem_q) count_d = count_q - CW'(1);
		count_w = LW'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			left_q      <= '0;
			rp_q        <= '0;
			first_q     <= 1'b0;
			ins_q       <= 1'b0;
			rem_q       <= 1'b0;
			ok_q        <= 1'b0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rv_s1 <= issue_c;
			if (cmd.load) begin
				left_q  <= CW'(len_x);
				rp_q    <= AW'(rp_x);
				first_q <= 1'b1;
				ins_q   <= is_add;
				rem_q   <= is_rem;
				ok_q    <= dec_ok;
			end else if (issue_c) begin
				left_q  <= left_q - CW'(1);
				rp_q    <= ins_q ? (rp_q - AW'(1)) : (rp_q + AW'(1));
				first_q <= 1'b0;
			end
			if (cmd.commit) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q <= AW'(pos_x);
			val_q <= item_value;
			res_q <= dec_res;
			st_q  <= dec_st;
		end
		if (issue_c) begin
			wa_s1    <= ins_q ? (rp_q + AW'(1)) : (rp_q - AW'(1));
			first_s1 <= first_q;
		end
		// first read of a remove or lookup is the returned entry
		if (capture_c) res_q <= rdata_s1;
		if (cmd.commit) begin
			res_out_q <= res_q;
			st_out_q  <= st_q;
			len_out_q <= count_w[ile_pkg::LEN_W-1:0];
		end
	end

	assign stat.walk_done = (left_q == '0);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign result_value = res_out_q;
	assign status       = st_out_q;
	assign fill_level   = len_out_q;
	assign out_valid    = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/indexed_list_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_engine_core
// Bounded ordered list of signed 32-bit values with insert, remove and
// read at front, back or a given position; one result per request.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit first)
//  s_axis  | in  | req_type[2:0] item_index[8:3] item_value[40:9]
//  m_axis  | out | result_value[31:0] status[33:32] fill_level[40:34]
//
//  Each request makes n store reads between acceptance and result, where n
//  is length - position for an insert or remove, 1 for a read and 0 for
//  a rejected request. The next request is taken only after the previous
//  one has committed; the store moves one entry per cycle.
//  Reset clears the length; store contents are don't-care until written.
//  A held result stalls the commit of the next request, not its acceptance.
// ----------------------------------------------------------------------------
module indexed_list_engine_core #(
	parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// req_type[2:0], item_index[8:3], item_value[40:9], zero pad
	input  wire logic [ile_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// result_value[31:0], status[33:32], fill_level[40:34], zero pad
	output logic [ile_pkg::M_TDATA_W-1:0]        m_tdata
);

	localparam int IN_USED  = ile_pkg::REQ_W + ile_pkg::IDX_W + ile_pkg::VAL_W;
	localparam int OUT_USED = ile_pkg::VAL_W + ile_pkg::ST_W + ile_pkg::LEN_W;

	ile_pkg::ile_cmd_t  cmd;
	ile_pkg::ile_stat_t stat;

	logic [ile_pkg::REQ_W-1:0]        req_type;
	logic [ile_pkg::IDX_W-1:0]        item_index;
	logic signed [ile_pkg::VAL_W-1:0] item_value;
	logic signed [ile_pkg::VAL_W-1:0] result_value;
	logic [ile_pkg::ST_W-1:0]         status;
	logic [ile_pkg::LEN_W-1:0]        fill_level;

	assign req_type   = s_tdata[ile_pkg::REQ_W-1:0];
	assign item_index = s_tdata[ile_pkg::REQ_W +: ile_pkg::IDX_W];
	assign item_value = s_tdata[ile_pkg::REQ_W + ile_pkg::IDX_W +: ile_pkg::VAL_W];

	assign m_tdata = {{(ile_pkg::M_TDATA_W - OUT_USED){1'b0}},
		fill_level, status, result_value};

	ile_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ile_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (req_type),
		.item_index   (item_index),
		.item_value   (item_value),
		.result_value (result_value),
		.status       (status),
		.fill_level   (fill_level),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready)
	);

	// upper tdata bits are padding
	logic unused_pad;
	assign unused_pad = ^s_tdata[ile_pkg::S_TDATA_W-1:IN_USED];

endmodule
`default_nettype wire
